>>> design/gaussian_taper_apply_unit_defines.svh
// assertion macros for the gaussian taper apply unit
`ifndef GAUSSIAN_TAPER_APPLY_UNIT_DEFINES_SVH
`define GAUSSIAN_TAPER_APPLY_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk with reset masking
`define GTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk with reset masking
`define GTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gta_pkg.sv
// shared constants and exponent table builders for the gaussian taper apply unit
package gta_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int EXP_TABLE_BITS_DEF = 8;

    localparam int ANGLE_WIDTH     = 18;
    localparam int COEF_WIDTH      = 24;
    localparam int ARG_FRAC_BITS   = 46;
    localparam int TAB_FRAC_BITS   = 30;
    localparam int TAB_WIDTH       = TAB_FRAC_BITS + 1;
    localparam int SERIES_FRAC     = 48;
    localparam int SERIES_TERMS    = 24;
    localparam int INT_BITS        = 4;
    localparam int INT_ENTRIES     = 1 << INT_BITS;
    localparam int FACTOR_FRAC     = 16;
    localparam int FACTOR_WIDTH    = FACTOR_FRAC + 1;
    localparam int SQ_WIDTH        = 2 * ANGLE_WIDTH - 1;
    localparam int SQ_SPLIT        = 17;
    localparam int NUM_LANES       = 8;
    localparam int CFG_INDEX_WIDTH = 4;

    // register map
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAPER_COEF  = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATRIX_MODE = CFG_INDEX_WIDTH'(1);

    // shift and subtract quotient, only used while building the tables
    function automatic longint unsigned div_floor(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-num / 2^tbits) in Q0.30 from a truncated alternating series,
    // k = 4 ln2 / fwhm^2 (about 2.77258872223978123767 / fwhm^2) comes from software
    function automatic logic [TAB_WIDTH-1:0] exp_neg_q30(input int unsigned num,
                                                         input int unsigned tbits);
        longint unsigned term;
        longint unsigned plus;
        longint unsigned minus;
        longint unsigned sum;
        term  = 64'd1 << SERIES_FRAC;
        plus  = term;
        minus = 64'd0;
        for (int unsigned n = 1; n <= SERIES_TERMS; n++)
        begin
            // floor of floor equals floor of the combined divisor
            term = div_floor((term * longint'(num)) >> tbits, longint'(n));
            if (n[0])
                minus = minus + term;
            else
                plus = plus + term;
        end
        sum = (plus >= minus) ? plus - minus : 64'd0;
        return TAB_WIDTH'((sum + (64'd1 << (SERIES_FRAC - TAB_FRAC_BITS - 1)))
                          >> (SERIES_FRAC - TAB_FRAC_BITS));
    endfunction

    // exp(-idx) in Q0.30 by repeated rounded multiplication with e1
    function automatic logic [TAB_WIDTH-1:0] int_entry(input int unsigned idx,
                                                       input logic [TAB_WIDTH-1:0] e1);
        longint unsigned v;
        v = 64'd1 << TAB_FRAC_BITS;
        for (int unsigned i = 1; i <= idx; i++)
        begin
            v = (v * longint'(e1) + (64'd1 << (TAB_FRAC_BITS - 1))) >> TAB_FRAC_BITS;
        end
        return TAB_WIDTH'(v);
    endfunction

endpackage

>>> design/gaussian_taper_apply_unit.sv
// gaussian taper apply unit: pipelined exp(-theta^2 k) factor and complex sample scaling
//
//  channel | signals                               | beat accepted when
//  --------+---------------------------------------+--------------------------
//  input   | in_valid in_stall angle aa..bb last_in| in_valid && !in_stall
//  output  | out_valid out_stall out_* last_out    | out_valid && !out_stall
//  config  | cfg_valid cfg_ready cfg_index cfg_data| cfg_valid && cfg_ready
//
// eight register stages, one beat per cycle sustained while the output is not stalled
// depth is set by the square, the split 35x24 argument multiply, the table
// lookups, the 31x31 table product and the per-lane scale and round
// reset clears valid bits and config registers; tables are constant logic
// a stalled output beat freezes every stage and raises in_stall
`include "gaussian_taper_apply_unit_defines.svh"

module gaussian_taper_apply_unit #(
    parameter int SAMPLE_WIDTH   = gta_pkg::SAMPLE_WIDTH_DEF,
    parameter int EXP_TABLE_BITS = gta_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gta_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [gta_pkg::COEF_WIDTH-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [gta_pkg::ANGLE_WIDTH-1:0] angle,
    input  logic signed [SAMPLE_WIDTH-1:0]        aa_re,
    input  logic signed [SAMPLE_WIDTH-1:0]        aa_im,
    input  logic signed [SAMPLE_WIDTH-1:0]        ab_re,
    input  logic signed [SAMPLE_WIDTH-1:0]        ab_im,
    input  logic signed [SAMPLE_WIDTH-1:0]        ba_re,
    input  logic signed [SAMPLE_WIDTH-1:0]        ba_im,
    input  logic signed [SAMPLE_WIDTH-1:0]        bb_re,
    input  logic signed [SAMPLE_WIDTH-1:0]        bb_im,
    input  logic                                  last_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        out_aa_re,
    output logic signed [SAMPLE_WIDTH-1:0]        out_aa_im,
    output logic signed [SAMPLE_WIDTH-1:0]        out_ab_re,
    output logic signed [SAMPLE_WIDTH-1:0]        out_ab_im,
    output logic signed [SAMPLE_WIDTH-1:0]        out_ba_re,
    output logic signed [SAMPLE_WIDTH-1:0]        out_ba_im,
    output logic signed [SAMPLE_WIDTH-1:0]        out_bb_re,
    output logic signed [SAMPLE_WIDTH-1:0]        out_bb_im,
    output logic                                  last_out
);

    localparam int STAGES       = 8;
    localparam int NL           = gta_pkg::NUM_LANES;
    localparam int AW           = gta_pkg::ANGLE_WIDTH;
    localparam int CW           = gta_pkg::COEF_WIDTH;
    localparam int TW           = gta_pkg::TAB_WIDTH;
    localparam int FW           = gta_pkg::FACTOR_WIDTH;
    localparam int FF           = gta_pkg::FACTOR_FRAC;
    localparam int IB           = gta_pkg::INT_BITS;
    localparam int SQW          = gta_pkg::SQ_WIDTH;
    localparam int SPL          = gta_pkg::SQ_SPLIT;
    localparam int FRAC_ENTRIES = 1 << EXP_TABLE_BITS;
    localparam int PLO_W        = SPL + CW;
    localparam int PHI_W        = (SQW - SPL) + CW;
    localparam int XW           = SQW + CW;
    localparam int SHIFT        = gta_pkg::ARG_FRAC_BITS - EXP_TABLE_BITS;
    localparam int QW           = XW + 1 - SHIFT;
    localparam int TPW          = 2 * TW;
    localparam int TP_SHIFT     = 2 * gta_pkg::TAB_FRAC_BITS - FF;
    localparam int SPW          = SAMPLE_WIDTH + FW;
    localparam int SRW          = SPW + 1;

    localparam logic [XW:0]  ARG_RND = (XW + 1)'(1) << (SHIFT - 1);
    localparam logic [TPW-1:0] TP_RND = TPW'(1) << (TP_SHIFT - 1);
    localparam logic [SRW-1:0] SP_RND = SRW'(1) << (FF - 1);
    localparam logic [TW-1:0] E1 = gta_pkg::exp_neg_q30(FRAC_ENTRIES, EXP_TABLE_BITS);
    localparam logic [SAMPLE_WIDTH-1:0] S_HI = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_LO = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
    localparam logic [FW-1:0] FACTOR_ONE = FW'(1) << FF;

    typedef logic [SAMPLE_WIDTH-1:0] lane_t;
    typedef lane_t lanes_t [NL];

    // exponent tables
    logic [TW-1:0] frac_rom [FRAC_ENTRIES];
    logic [TW-1:0] int_rom  [gta_pkg::INT_ENTRIES];

    for (genvar f = 0; f < FRAC_ENTRIES; f++)
    begin : g_frac_rom
        assign frac_rom[f] = gta_pkg::exp_neg_q30(f, EXP_TABLE_BITS);
    end

    for (genvar i = 0; i < gta_pkg::INT_ENTRIES; i++)
    begin : g_int_rom
        assign int_rom[i] = gta_pkg::int_entry(i, E1);
    end

    // configuration
    logic [CW-1:0] coef_reg;
    logic          mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gta_pkg::REG_TAPER_COEF:  coef_reg <= cfg_data;
                gta_pkg::REG_MATRIX_MODE: mode_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // pipeline control
    logic [STAGES-1:0] vld_reg;
    logic              en;

    assign en       = !(vld_reg[STAGES-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
    end

    // payload stages
    lanes_t          in_lane;
    lanes_t          lane_s1_reg, lane_s2_reg, lane_s3_reg, lane_s4_reg;
    lanes_t          lane_s5_reg, lane_s6_reg, lane_s7_reg, lane_out_reg;
    lanes_t          lane_out_next;
    logic [STAGES-1:0] last_reg;

    logic [AW-1:0]    mag_s1_reg;
    logic [SQW-1:0]   sq_s2_reg;
    logic [PLO_W-1:0] plo_s3_reg;
    logic [PHI_W-1:0] phi_s3_reg;
    logic [XW:0]      arg_rnd;
    logic [QW-1:0]    q_val;
    logic             sat_s4_reg, sat_s5_reg;
    logic [IB-1:0]    ip_s4_reg;
    logic [EXP_TABLE_BITS-1:0] fp_s4_reg;
    logic [TW-1:0]    ival_s5_reg, fval_s5_reg;
    logic [TPW-1:0]   tprod;
    logic [TPW-1:0]   tprod_rnd;
    logic [FW-1:0]    factor_s6_reg;
    logic [SPW-1:0]   sprod_next [NL];
    logic [SPW-1:0]   sprod_s7_reg [NL];

    assign in_lane[0] = aa_re;
    assign in_lane[1] = aa_im;
    assign in_lane[2] = ab_re;
    assign in_lane[3] = ab_im;
    assign in_lane[4] = ba_re;
    assign in_lane[5] = ba_im;
    assign in_lane[6] = bb_re;
    assign in_lane[7] = bb_im;

    // argument = theta^2 * k from two partial products
    assign arg_rnd = (XW + 1)'(plo_s3_reg) + (XW + 1)'({phi_s3_reg, {SPL{1'b0}}}) + ARG_RND;
    assign q_val   = arg_rnd[XW:SHIFT];

    assign tprod     = TPW'(ival_s5_reg) * TPW'(fval_s5_reg);
    assign tprod_rnd = tprod + TP_RND;

    // magnitude taken at sample width, then widened for the product
    always_comb
    begin
        lane_t smag;
        for (int j = 0; j < NL; j++)
        begin
            smag          = lane_s6_reg[j][SAMPLE_WIDTH-1] ? -lane_s6_reg[j] : lane_s6_reg[j];
            sprod_next[j] = SPW'(smag) * SPW'(factor_s6_reg);
        end
    end

    // round to nearest away from zero, saturate, then pick per lane
    always_comb
    begin
        logic [SRW-1:0]          rsum;
        logic [SRW-FF-1:0]       rmag;
        logic                    neg;
        logic [SAMPLE_WIDTH-1:0] scaled;
        for (int j = 0; j < NL; j++)
        begin
            rsum = SRW'(sprod_s7_reg[j]) + SP_RND;
            rmag = rsum[SRW-1:FF];
            neg  = lane_s7_reg[j][SAMPLE_WIDTH-1];
            if (!neg && (rmag > (SRW - FF)'(S_HI)))
                scaled = S_HI;
            else if (neg && (rmag > (SRW - FF)'(S_LO)))
                scaled = S_LO;
            else if (neg)
                scaled = -rmag[SAMPLE_WIDTH-1:0];
            else
                scaled = rmag[SAMPLE_WIDTH-1:0];
            lane_out_next[j] = (j < 2 || mode_reg) ? scaled : lane_s7_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg     <= {last_reg[STAGES-2:0], last_in};
            lane_s1_reg  <= in_lane;
            lane_s2_reg  <= lane_s1_reg;
            lane_s3_reg  <= lane_s2_reg;
            lane_s4_reg  <= lane_s3_reg;
            lane_s5_reg  <= lane_s4_reg;
            lane_s6_reg  <= lane_s5_reg;
            lane_s7_reg  <= lane_s6_reg;
            lane_out_reg <= lane_out_next;

            mag_s1_reg <= angle[AW-1] ? AW'(-angle) : AW'(angle);
            sq_s2_reg  <= SQW'(mag_s1_reg * mag_s1_reg);
            plo_s3_reg <= PLO_W'(sq_s2_reg[SPL-1:0]) * PLO_W'(coef_reg);
            phi_s3_reg <= PHI_W'(sq_s2_reg[SQW-1:SPL]) * PHI_W'(coef_reg);

            sat_s4_reg <= |q_val[QW-1:EXP_TABLE_BITS+IB];
            ip_s4_reg  <= q_val[EXP_TABLE_BITS+IB-1:EXP_TABLE_BITS];
            fp_s4_reg  <= q_val[EXP_TABLE_BITS-1:0];

            sat_s5_reg  <= sat_s4_reg;
            ival_s5_reg <= int_rom[ip_s4_reg];
            fval_s5_reg <= frac_rom[fp_s4_reg];

            factor_s6_reg <= sat_s5_reg ? '0 : tprod_rnd[TP_SHIFT+FW-1:TP_SHIFT];
            sprod_s7_reg  <= sprod_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_aa_re = lane_out_reg[0];
    assign out_aa_im = lane_out_reg[1];
    assign out_ab_re = lane_out_reg[2];
    assign out_ab_im = lane_out_reg[3];
    assign out_ba_re = lane_out_reg[4];
    assign out_ba_im = lane_out_reg[5];
    assign out_bb_re = lane_out_reg[6];
    assign out_bb_im = lane_out_reg[7];
    assign last_out  = last_reg[STAGES-1];

    `GTA_ASSERT_NEXT(a_sat_zero_factor, vld_reg[4] && en && sat_s5_reg, factor_s6_reg == '0, "saturated argument did not give a zero factor")
    `GTA_ASSERT_NOW(a_factor_range, vld_reg[5], factor_s6_reg <= FACTOR_ONE, "taper factor above one")
    `GTA_ASSERT_NEXT(a_valid_advance, en, vld_reg[STAGES-1] == $past(vld_reg[STAGES-2]), "valid bit lost or repeated between stages")
    `GTA_ASSERT_NEXT(a_stall_freeze, !en, vld_reg == $past(vld_reg), "pipeline moved while stalled")

endmodule

>>> tb/sv/gaussian_taper_apply_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the gaussian taper apply unit with its own taper predictor
module gaussian_taper_apply_unit_tb;

    localparam int SW         = gta_pkg::SAMPLE_WIDTH_DEF;
    localparam int AW         = gta_pkg::ANGLE_WIDTH;
    localparam int CW         = gta_pkg::COEF_WIDTH;
    localparam int IW         = gta_pkg::CFG_INDEX_WIDTH;
    localparam int TBITS      = gta_pkg::EXP_TABLE_BITS_DEF;
    localparam int ARG_SHIFT  = 46 - TBITS;
    localparam int LUT_FRAC   = 30;
    localparam int INT_SLOTS  = 16;
    localparam int PIPE_DEPTH = 8;
    localparam int IDLE_PCT   = 27;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_BEATS = 86;
    localparam longint SAMPLE_MAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam logic [gta_pkg::CFG_INDEX_WIDTH-1:0] REG_FIRST_UNUSED =
        gta_pkg::REG_MATRIX_MODE + 1'b1;

    typedef struct packed {
        logic [AW-1:0]       angle;
        logic [7:0][SW-1:0]  lane;
        logic                last;
    } source_t;

    typedef struct packed {
        logic [7:0][SW-1:0]  lane;
        logic                last;
    } tapered_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [gta_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [AW-1:0] angle = '0;
    logic signed [SW-1:0] aa_re = '0, aa_im = '0, ab_re = '0, ab_im = '0;
    logic signed [SW-1:0] ba_re = '0, ba_im = '0, bb_re = '0, bb_im = '0;
    logic last_in = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SW-1:0] out_aa_re, out_aa_im, out_ab_re, out_ab_im;
    logic signed [SW-1:0] out_ba_re, out_ba_im, out_bb_re, out_bb_im;
    logic last_out;

    longint unsigned exp_int_lut [INT_SLOTS];
    longint unsigned exp_frac_lut [1 << TBITS];
    logic [CW-1:0] coef_shadow = '0;
    logic          matrix_shadow = 1'b0;

    source_t  source_q [$];
    tapered_t taper_results_q [$];
    source_t  drv_item = '0;
    bit       no_gaps = 1'b0;
    int       mismatch_cnt = 0;
    int       checked_cnt = 0;
    int       zeroed_cnt = 0;
    int       settings_cnt = 1;
    string    lane_name [8] = '{"aa_re", "aa_im", "ab_re", "ab_im",
                                "ba_re", "ba_im", "bb_re", "bb_im"};

    gaussian_taper_apply_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .angle(angle),
        .aa_re(aa_re), .aa_im(aa_im), .ab_re(ab_re), .ab_im(ab_im),
        .ba_re(ba_re), .ba_im(ba_im), .bb_re(bb_re), .bb_im(bb_im),
        .last_in(last_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_aa_re(out_aa_re), .out_aa_im(out_aa_im),
        .out_ab_re(out_ab_re), .out_ab_im(out_ab_im),
        .out_ba_re(out_ba_re), .out_ba_im(out_ba_im),
        .out_bb_re(out_bb_re), .out_bb_im(out_bb_im),
        .last_out(last_out)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // exp(-num / 2^TBITS) in Q0.30, alternating series with truncated terms
    function automatic longint unsigned neg_exp_q30(int unsigned num);
        longint unsigned term;
        longint unsigned plus;
        longint unsigned minus;
        longint unsigned sum;
        term  = 64'd1 << 48;
        plus  = term;
        minus = 64'd0;
        for (int n = 1; n <= 24; n++)
        begin
            term = (term * num) / (longint'(n) << TBITS);
            if (n % 2 == 1)
                minus += term;
            else
                plus += term;
        end
        sum = (plus >= minus) ? plus - minus : 64'd0;
        return (sum + (64'd1 << 17)) >> 18;
    endfunction

    // taper factor in Q1.16 for the current coefficient
    function automatic longint unsigned taper_gain(logic [AW-1:0] ang);
        longint          a;
        longint unsigned mag;
        longint unsigned x;
        longint unsigned q;
        a   = longint'($signed(ang));
        mag = (a < 0) ? -a : a;
        x   = mag * mag * longint'(coef_shadow);
        q   = (x + (64'd1 << (ARG_SHIFT - 1))) >> ARG_SHIFT;
        if (q >= (64'(INT_SLOTS) << TBITS))
            return 64'd0;
        return (exp_int_lut[q >> TBITS] * exp_frac_lut[q & ((64'd1 << TBITS) - 1)]
                + (64'd1 << 43)) >> 44;
    endfunction

    // magnitude scaled with round half away from zero, then clamped
    function automatic logic [SW-1:0] scale_lane(logic [SW-1:0] v, longint unsigned gain);
        longint          s;
        longint          r;
        longint unsigned mag;
        s   = longint'($signed(v));
        mag = (s < 0) ? -s : s;
        r   = longint'((mag * gain + 64'd32768) >> 16);
        if (s < 0)
            r = -r;
        if (r > SAMPLE_MAX)
            r = SAMPLE_MAX;
        if (r < SAMPLE_MIN)
            r = SAMPLE_MIN;
        return r[SW-1:0];
    endfunction

    function automatic tapered_t taper_beat(source_t src);
        tapered_t        res;
        longint unsigned gain;
        gain = taper_gain(src.angle);
        for (int j = 0; j < 8; j++)
        begin
            if (j < 2 || matrix_shadow)
                res.lane[j] = scale_lane(src.lane[j], gain);
            else
                res.lane[j] = src.lane[j];
        end
        res.last = src.last;
        return res;
    endfunction

    function automatic source_t random_source();
        source_t s;
        int      a;
        if ($urandom_range(1))
            a = $urandom;
        else
        begin
            a = $urandom_range(0, 1 << $urandom_range(0, 16));
            if ($urandom_range(1))
                a = -a;
        end
        s.angle = a[AW-1:0];
        for (int j = 0; j < 8; j++)
        begin
            case ($urandom_range(9))
                0: s.lane[j] = SAMPLE_MAX[SW-1:0];
                1: s.lane[j] = SAMPLE_MIN[SW-1:0];
                2: s.lane[j] = '0;
                default: s.lane[j] = SW'($urandom);
            endcase
        end
        s.last = ($urandom_range(7) == 0);
        return s;
    endfunction

    task automatic add_source(int ang, int re, int im, bit last);
        source_t s;
        s.angle = ang[AW-1:0];
        for (int j = 0; j < 8; j++)
            s.lane[j] = (j % 2 == 0) ? re[SW-1:0] : im[SW-1:0];
        s.last = last;
        source_q.push_back(s);
    endtask

    task automatic write_reg(logic [gta_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == gta_pkg::REG_TAPER_COEF)
            coef_shadow = data;
        else if (idx == gta_pkg::REG_MATRIX_MODE)
            matrix_shadow = data[0];
        cfg_valid <= 1'b0;
    endtask

    // drain everything in flight, then let the pipeline settle
    task automatic wait_drained();
        while (source_q.size() != 0 || in_valid || taper_results_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // source driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                taper_results_q.push_back(taper_beat(drv_item));
                if (taper_gain(drv_item.angle) == 0)
                    zeroed_cnt++;
            end
            if (source_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT))
            begin
                drv_item = source_q.pop_front();
                in_valid <= 1'b1;
                angle    <= drv_item.angle;
                aa_re    <= drv_item.lane[0];
                aa_im    <= drv_item.lane[1];
                ab_re    <= drv_item.lane[2];
                ab_im    <= drv_item.lane[3];
                ba_re    <= drv_item.lane[4];
                ba_im    <= drv_item.lane[5];
                bb_re    <= drv_item.lane[6];
                bb_im    <= drv_item.lane[7];
                last_in  <= drv_item.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and output backpressure
    always @(posedge clk)
    begin
        tapered_t got;
        tapered_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.lane = {out_bb_im, out_bb_re, out_ba_im, out_ba_re,
                            out_ab_im, out_ab_re, out_aa_im, out_aa_re};
                got.last = last_out;
                if (taper_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat", $time);
                    mismatch_cnt++;
                end
                else
                begin
                    want = taper_results_q.pop_front();
                    checked_cnt++;
                    for (int j = 0; j < 8; j++)
                    begin
                        if (got.lane[j] !== want.lane[j])
                        begin
                            $display("%0t: out_%s expected %0d got %0d", $time, lane_name[j],
                                     $signed(want.lane[j]), $signed(got.lane[j]));
                            mismatch_cnt++;
                        end
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: last_out expected %0b got %0b", $time,
                                 want.last, got.last);
                        mismatch_cnt++;
                    end
                end
            end
            out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        longint unsigned e1;
        logic [CW-1:0]   coef;
        for (int f = 0; f < (1 << TBITS); f++)
            exp_frac_lut[f] = neg_exp_q30(f);
        e1 = neg_exp_q30(1 << TBITS);
        exp_int_lut[0] = 64'd1 << LUT_FRAC;
        for (int i = 1; i < INT_SLOTS; i++)
            exp_int_lut[i] = (exp_int_lut[i - 1] * e1 + (64'd1 << (LUT_FRAC - 1))) >> LUT_FRAC;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: zero coefficient passes values, scalar mode
        add_source(0, 'h7fffff, 'h800000, 1'b0);
        add_source(1, 'h800000, 'h7fffff, 1'b1);
        add_source(-1, 0, 1, 1'b0);
        add_source(131071, -1, 1, 1'b0);
        add_source(-131072, 'h400000, 'hc00000, 1'b1);
        wait_drained();

        // k near 2.77, matrix mode written with upper junk bits; sweep the cutoff
        write_reg(gta_pkg::REG_TAPER_COEF, 24'h02c5c8);
        write_reg(gta_pkg::REG_MATRIX_MODE, 24'hffffff);
        write_reg(REG_FIRST_UNUSED, 24'h5a5a5a);
        settings_cnt++;
        add_source(0, 'h7fffff, 'h800000, 1'b0);
        add_source(1, 'h800000, 'h7fffff, 1'b0);
        add_source(-1, 'h7fffff, -1, 1'b1);
        add_source(16384, 'h123456, -'h123456, 1'b0);
        add_source(-32768, 'h800000, 'h7fffff, 1'b0);
        add_source(65536, 'h7fffff, 'h800000, 1'b0);
        add_source(78000, 'h7fffff, 'h800000, 1'b1);
        add_source(78716, 'h7fffff, 'h800000, 1'b0);
        add_source(78717, 'h7fffff, 'h800000, 1'b0);
        add_source(-79000, 'h800000, 'h7fffff, 1'b0);
        add_source(131071, 'h7fffff, 'h800000, 1'b1);
        add_source(-131072, 'h800000, 'h7fffff, 1'b0);
        wait_drained();

        // largest coefficient, scalar mode: cutoff sits at a quarter radian
        write_reg(gta_pkg::REG_TAPER_COEF, 24'hffffff);
        write_reg(gta_pkg::REG_MATRIX_MODE, 24'hfffffe);
        settings_cnt++;
        add_source(8191, 'h7fffff, 'h800000, 1'b0);
        add_source(8192, 'h7fffff, 'h800000, 1'b1);
        add_source(-8191, 'h800000, 'h7fffff, 1'b0);
        add_source(0, 'h7fffff, 'h800000, 1'b0);
        add_source(100, -1, 1, 1'b1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            coef = (ph == 0) ? 24'd1
                             : CW'($urandom_range(0, (1 << $urandom_range(1, CW)) - 1));
            write_reg(gta_pkg::REG_TAPER_COEF, coef);
            write_reg(gta_pkg::REG_MATRIX_MODE, CW'($urandom));
            write_reg(IW'($urandom_range(REG_FIRST_UNUSED, (1 << IW) - 1)),
                      CW'($urandom));
            settings_cnt++;
            no_gaps = (ph == 3);
            for (int k = 0; k < PHASE_BEATS; k++)
                source_q.push_back(random_source());
            wait_drained();
        end
        no_gaps = 1'b0;

        $display("checked %0d result beats across %0d register settings", checked_cnt,
                 settings_cnt);
        $display("%0d of them with the taper factor cut to zero", zeroed_cnt);
        if (mismatch_cnt == 0 && taper_results_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
